/* rtl/bsna_pkg.sv */
// Package: shared constants, types and codes of the bitmap slab node allocator.
`default_nettype none
package bsna_pkg;
  localparam int unsigned NODES     = 64;
  localparam int unsigned MAXC      = 16;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CNT_W     = 5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSLOT  = 2'd1;
  localparam logic [1:0] ST_BADARG  = 2'd2;
  localparam logic [1:0] ST_DBLFREE = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [NODES-1:0]  bits;
  } cell_t;

  typedef enum logic [1:0] {
    CK_NONE,
    CK_WRITE,
    CK_SHIFT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [SLOT_W-1:0] pos;
    cell_t             data;
  } cmd_t;
endpackage
`default_nettype wire

/* rtl/bsna_if.sv */
// Interfaces: request and result channels of the allocator.
`default_nettype none
interface bsna_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] free_slot;
  logic [5:0] free_index;
  modport source (output valid, opcode, free_slot, free_index, input ready);
  modport sink (input valid, opcode, free_slot, free_index, output ready);
endinterface

interface bsna_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] given_slot;
  logic [5:0] given_index;
  logic       container_released;
  modport source (output valid, status, given_slot, given_index, container_released,
                  input ready);
  modport sink (input valid, status, given_slot, given_index, container_released,
                output ready);
endinterface
`default_nettype wire

/* rtl/bsna_cell.sv */
// Cell: one search-order position holding a container slot and its bitmap.
`default_nettype none
module bsna_cell import bsna_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SLOT_W-1:0] pos_i,
  input  wire cmd_t              cmd_i,
  input  wire cell_t             next_i,
  output      cell_t             cell_o
);
  cell_t cell_q, cell_d;

  always_comb begin
    cell_d = cell_q;
    case (cmd_i.kind)
      CK_WRITE: if (cmd_i.pos == pos_i) cell_d = cmd_i.data;
      CK_SHIFT: if (pos_i >= cmd_i.pos) cell_d = next_i;
      default:  cell_d = cell_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule
`default_nettype wire

/* rtl/bitmap_slab_node_allocator.sv */
// Top level: bitmap slab node allocator built on a chain of search-order cells.
`default_nettype none
// First-fit node allocator over up to 16 containers of 64 nodes each. Slot 0
// is permanent and heads the search order. An allocate scans the chain from
// its head: the scan reads one cell of the chain per cycle while the output
// register is free, and does a find-first-zero over its bitmap. A free first
// locates the cell, then updates it, or shifts the chain left by one to unlink
// an emptied container. One request is in flight at a time; a result waits in
// an output register until taken.
module bitmap_slab_node_allocator import bsna_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  bsna_req_if.sink req_i,
  bsna_rsp_if.source rsp_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FRD  = 2'd2;
  localparam logic [1:0] S_FDO  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MAXC-1:0]   act_q, act_d;
  logic [SLOT_W-1:0] fslot_q;
  logic [IDX_W-1:0]  fidx_q;
  logic [SLOT_W-1:0] fpos_q, fpos_d;
  logic [NODES-1:0]  fbits_q, fbits_d;

  logic              ovld_q, ovld_d;
  logic [1:0]        ost_q, ost_d;
  logic [SLOT_W-1:0] oslot_q, oslot_d;
  logic [IDX_W-1:0]  oidx_q, oidx_d;
  logic              orel_q, orel_d;

  cell_t cells [MAXC];
  cmd_t  cmd;

  for (genvar k = 0; k < MAXC; k++) begin : g_cell
    cell_t nxt;
    if (k == MAXC - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cells[k+1];
    end
    bsna_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pos_i  (SLOT_W'(k)),
      .cmd_i  (cmd),
      .next_i (nxt),
      .cell_o (cells[k])
    );
  end

  cell_t             cur;
  logic              z_found;
  logic [IDX_W-1:0]  z_idx;
  logic              ns_found;
  logic [SLOT_W-1:0] ns_slot;
  logic [SLOT_W-1:0] hit_pos;
  logic [NODES-1:0]  nb;
  logic              out_free;

  assign cur = cells[ptr_q];
  assign out_free = !ovld_q || rsp_o.ready;
  assign nb = fbits_q & ~(NODES'(1) << fidx_q);

  always_comb begin
    z_found = 1'b0;
    z_idx   = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (!cur.bits[i]) begin
        z_found = 1'b1;
        z_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    ns_found = 1'b0;
    ns_slot  = '0;
    for (int i = MAXC - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        ns_found = 1'b1;
        ns_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < MAXC; i++) begin
      if (CNT_W'(i) < cnt_q && cells[i].slot == fslot_q) hit_pos = hit_pos | SLOT_W'(i);
    end
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    act_d   = act_q;
    fpos_d  = fpos_q;
    fbits_d = fbits_q;
    ovld_d  = ovld_q && !rsp_o.ready;
    ost_d   = ost_q;
    oslot_d = oslot_q;
    oidx_d  = oidx_q;
    orel_d  = orel_q;
    cmd     = '{kind: CK_NONE, pos: '0, data: '0};
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          ptr_d   = '0;
          state_d = (req_i.opcode == OP_FREE) ? S_FRD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ost_d   = ST_OK;
          oslot_d = '0;
          oidx_d  = '0;
          orel_d  = 1'b0;
          state_d = S_IDLE;
          if (z_found) begin
            cmd.kind = CK_WRITE;
            cmd.pos  = ptr_q;
            cmd.data = '{slot: cur.slot, bits: cur.bits | (NODES'(1) << z_idx)};
            oslot_d  = cur.slot;
            oidx_d   = z_idx;
          end else if (CNT_W'(ptr_q) + CNT_W'(1) < cnt_q) begin
            ovld_d  = ovld_q && !rsp_o.ready;
            ptr_d   = ptr_q + SLOT_W'(1);
            state_d = S_SCAN;
          end else if (!ns_found || cnt_q >= CNT_W'(MAXC)) begin
            ost_d = ST_NOSLOT;
          end else begin
            cmd.kind        = CK_WRITE;
            cmd.pos         = cnt_q[SLOT_W-1:0];
            cmd.data        = '{slot: ns_slot, bits: NODES'(1)};
            act_d[ns_slot]  = 1'b1;
            cnt_d           = cnt_q + CNT_W'(1);
            oslot_d         = ns_slot;
          end
        end
      end
      S_FRD: begin
        fpos_d  = hit_pos;
        fbits_d = cells[hit_pos].bits;
        state_d = S_FDO;
      end
      S_FDO: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          ost_d   = ST_OK;
          oslot_d = '0;
          oidx_d  = '0;
          orel_d  = 1'b0;
          state_d = S_IDLE;
          if (!act_q[fslot_q]) begin
            ost_d = ST_BADARG;
          end else if (!fbits_q[fidx_q]) begin
            ost_d = ST_DBLFREE;
          end else if (fslot_q != '0 && nb == '0) begin
            cmd.kind        = CK_SHIFT;
            cmd.pos         = fpos_q;
            cnt_d           = cnt_q - CNT_W'(1);
            act_d[fslot_q]  = 1'b0;
            orel_d          = 1'b1;
          end else begin
            cmd.kind = CK_WRITE;
            cmd.pos  = fpos_q;
            cmd.data = '{slot: fslot_q, bits: nb};
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      cnt_q   <= CNT_W'(1);
      act_q   <= MAXC'(1);
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      act_q   <= act_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      fslot_q <= req_i.free_slot;
      fidx_q  <= req_i.free_index;
    end
    fpos_q  <= fpos_d;
    fbits_q <= fbits_d;
    ost_q   <= ost_d;
    oslot_q <= oslot_d;
    oidx_q  <= oidx_d;
    orel_q  <= orel_d;
  end

  assign rsp_o.valid              = ovld_q;
  assign rsp_o.status             = ost_q;
  assign rsp_o.given_slot         = oslot_q;
  assign rsp_o.given_index        = oidx_q;
  assign rsp_o.container_released = orel_q;
endmodule
`default_nettype wire
